[hdl/fuhs_pkg.sv]
// Shared types, codes and constants for the firmware upgrade host sequencer.
package fuhs_pkg;

   localparam int MAX_PAYLOAD_DEF = 256;
   localparam int VERSION_MAX_DEF = 32;
   localparam int RETRY_LIMIT_DEF = 3;

   localparam int WORD_W   = 32;
   localparam int HALF_W   = 16;
   localparam int LABEL_W  = 6;
   localparam int LENGTH_W = 9;
   localparam int DLEN_W   = 8;
   localparam int CSR_IDX_W = 2;

   // reply codes that always end the session
   localparam logic [3:0] REPLY_NACK  = 4'd8;
   localparam logic [3:0] REPLY_ERROR = 4'd9;

   // payload lengths in bytes
   localparam logic [LENGTH_W-1:0] LEN_REPLY_PAIR = 9'd8;
   localparam logic [LENGTH_W-1:0] LEN_REPLY_WORD = 9'd4;
   localparam logic [LENGTH_W-1:0] LEN_SESSION    = 9'd4;
   localparam logic [LENGTH_W-1:0] LEN_REBOOT     = 9'd1;
   localparam logic [LENGTH_W-1:0] LEN_BEGIN_HDR  = 9'd11;
   localparam int                  DATA_HDR_BYTES = 8;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_BUILD   = 2'd1,
      OP_ACCEPT  = 2'd2,
      OP_RECOVER = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_ENTER    = 3'd0,
      KIND_BEGIN    = 3'd1,
      KIND_DATA     = 3'd2,
      KIND_STATUS   = 3'd3,
      KIND_END      = 3'd4,
      KIND_VERIFY   = 3'd5,
      KIND_ACTIVATE = 3'd6,
      KIND_REBOOT   = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_STATE    = 3'd2,
      ST_PROTOCOL = 3'd3,
      ST_TIMEOUT  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_VALIDATING = 4'd1,
      PH_ENTER      = 4'd2,
      PH_BEGIN      = 4'd3,
      PH_TRANSFER   = 4'd4,
      PH_RECOVER    = 4'd5,
      PH_END        = 4'd6,
      PH_VERIFY     = 4'd7,
      PH_ACTIVATE   = 4'd8,
      PH_REBOOT     = 4'd9,
      PH_COMPLETE   = 4'd10,
      PH_ERROR      = 4'd11
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_LENGTH   = 2'd0,
      CSR_IMAGE_CHECKSUM = 2'd1,
      CSR_CHUNK_LIMIT    = 2'd2,
      CSR_LABEL_LENGTH   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [2:0]          sent_kind;
      logic [3:0]          reply_kind;
      logic [LENGTH_W-1:0] reply_length;
      logic [WORD_W-1:0]   reply_word_a;
      logic [WORD_W-1:0]   reply_word_b;
   } req_item_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [2:0]          frame_kind;
      logic [WORD_W-1:0]   frame_word_a;
      logic [WORD_W-1:0]   frame_word_b;
      logic [HALF_W-1:0]   frame_half;
      logic [LENGTH_W-1:0] frame_length;
      logic [DLEN_W-1:0]   data_length;
      logic [3:0]          phase;
      logic                busy_res;
      logic [WORD_W-1:0]   chunks_out;
   } rsp_item_type;

   typedef struct packed {
      logic [WORD_W-1:0]  image_length;
      logic [WORD_W-1:0]  image_checksum;
      logic [HALF_W-1:0]  chunk_limit;
      logic [LABEL_W-1:0] label_length;
      logic               start_ok;
   } csr_type;

endpackage

[hdl/fuhs_req_if.sv]
// Request channel interface: valid/ready handshake with the item fields.
interface fuhs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  sent_kind;
   logic [3:0]  reply_kind;
   logic [8:0]  reply_length;
   logic [31:0] reply_word_a;
   logic [31:0] reply_word_b;

   modport source (output valid, opcode, sent_kind, reply_kind, reply_length,
                   reply_word_a, reply_word_b, input ready);
   modport sink (input valid, opcode, sent_kind, reply_kind, reply_length,
                 reply_word_a, reply_word_b, output ready);
endinterface

[hdl/fuhs_rsp_if.sv]
// Response channel interface: valid/ready handshake with the result fields.
interface fuhs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [2:0]  frame_kind;
   logic [31:0] frame_word_a;
   logic [31:0] frame_word_b;
   logic [15:0] frame_half;
   logic [8:0]  frame_length;
   logic [7:0]  data_length;
   logic [3:0]  phase;
   logic        busy_res;
   logic [31:0] chunks_out;

   modport source (output valid, status, frame_kind, frame_word_a, frame_word_b,
                   frame_half, frame_length, data_length, phase, busy_res,
                   chunks_out, input ready);
   modport sink (input valid, status, frame_kind, frame_word_a, frame_word_b,
                 frame_half, frame_length, data_length, phase, busy_res,
                 chunks_out, output ready);
endinterface

[hdl/fuhs_csr.sv]
// Configuration registers and the start-time range check on them.
module fuhs_csr
   import fuhs_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int VERSION_MAX = VERSION_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data,
   output csr_type              csr
);

   localparam logic [HALF_W-1:0] CHUNK_CAP = HALF_W'(MAX_PAYLOAD - DATA_HDR_BYTES);
   localparam logic [7:0]        LABEL_CAP = 8'(VERSION_MAX);

   logic [WORD_W-1:0]  image_length_ff;
   logic [WORD_W-1:0]  image_checksum_ff;
   logic [HALF_W-1:0]  chunk_limit_ff;
   logic [LABEL_W-1:0] label_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_length_ff   <= '0;
         image_checksum_ff <= '0;
         chunk_limit_ff    <= '0;
         label_length_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_LENGTH:   image_length_ff   <= csr_write_data;
            CSR_IMAGE_CHECKSUM: image_checksum_ff <= csr_write_data;
            CSR_CHUNK_LIMIT:    chunk_limit_ff    <= csr_write_data[HALF_W-1:0];
            CSR_LABEL_LENGTH:   label_length_ff   <= csr_write_data[LABEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr.image_length   = image_length_ff;
      csr.image_checksum = image_checksum_ff;
      csr.chunk_limit    = chunk_limit_ff;
      csr.label_length   = label_length_ff;
      csr.start_ok       = (image_length_ff != '0) && (chunk_limit_ff != '0) &&
                           (chunk_limit_ff <= CHUNK_CAP) && (label_length_ff != '0) &&
                           ({2'b00, label_length_ff} <= LABEL_CAP);
   end

endmodule

[hdl/fuhs_engine.sv]
// Session state registers and the per-transaction next-state and frame logic.
module fuhs_engine
   import fuhs_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int RETRY_LIMIT = RETRY_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  csr_type      csr,
   output rsp_item_type result
);

   localparam logic [HALF_W-1:0] CHUNK_CAP = HALF_W'(MAX_PAYLOAD - DATA_HDR_BYTES);
   localparam logic [1:0]        RETRY_CAP = 2'(RETRY_LIMIT);

   phase_type         phase_ff, phase_in;
   logic [WORD_W-1:0] session_ff, session_in;
   logic [WORD_W-1:0] offset_ff, offset_in;
   logic [WORD_W-1:0] chunk_end_ff, chunk_end_in;
   logic [WORD_W-1:0] chunk_count_ff, chunk_count_in;
   logic [1:0]        retry_count_ff, retry_count_in;

   logic [WORD_W-1:0] remaining;
   logic [HALF_W-1:0] chunk_lim;
   logic [HALF_W-1:0] chunk;
   logic [HALF_W:0]   data_frame_len;
   phase_type         phase_after_a;
   phase_type         phase_after_b;
   logic              ok;

   always_comb begin
      remaining      = csr.image_length - offset_ff;
      chunk_lim      = (remaining < {{(WORD_W-HALF_W){1'b0}}, csr.chunk_limit}) ?
                       remaining[HALF_W-1:0] : csr.chunk_limit;
      chunk          = (chunk_lim > CHUNK_CAP) ? CHUNK_CAP : chunk_lim;
      data_frame_len = {1'b0, chunk} + (HALF_W+1)'(DATA_HDR_BYTES);
      // end of image decides between another chunk and the end request
      phase_after_a  = (item.reply_word_a == csr.image_length) ? PH_END : PH_TRANSFER;
      phase_after_b  = (item.reply_word_b == csr.image_length) ? PH_END : PH_TRANSFER;
   end

   always_comb begin
      phase_in       = phase_ff;
      session_in     = session_ff;
      offset_in      = offset_ff;
      chunk_end_in   = chunk_end_ff;
      chunk_count_in = chunk_count_ff;
      retry_count_in = retry_count_ff;
      ok             = 1'b0;
      result         = '0;
      result.status  = ST_OK;

      case (opcode_type'(item.opcode))
         OP_START: begin
            if (!csr.start_ok) begin
               result.status = ST_INVALID;
            end else begin
               phase_in       = PH_ENTER;
               session_in     = '0;
               offset_in      = '0;
               chunk_end_in   = '0;
               chunk_count_in = '0;
               retry_count_in = '0;
            end
         end
         OP_BUILD: begin
            case (phase_ff)
               PH_ENTER: begin
                  result.frame_kind = KIND_ENTER;
               end
               PH_BEGIN: begin
                  result.frame_kind   = KIND_BEGIN;
                  result.frame_word_a = csr.image_length;
                  result.frame_word_b = csr.image_checksum;
                  result.frame_half   = csr.chunk_limit;
                  result.frame_length = LEN_BEGIN_HDR + {3'b000, csr.label_length};
               end
               PH_TRANSFER: begin
                  if (offset_ff >= csr.image_length) begin
                     result.status = ST_STATE;
                  end else begin
                     result.frame_kind   = KIND_DATA;
                     result.frame_word_a = session_ff;
                     result.frame_word_b = offset_ff;
                     result.frame_length = data_frame_len[LENGTH_W-1:0];
                     result.data_length  = chunk[DLEN_W-1:0];
                     chunk_end_in   = offset_ff + {{(WORD_W-HALF_W){1'b0}}, chunk};
                     chunk_count_in = chunk_count_ff + 32'd1;
                  end
               end
               PH_RECOVER: begin
                  if (session_ff == '0) begin
                     result.status = ST_STATE;
                  end else begin
                     result.frame_kind   = KIND_STATUS;
                     result.frame_word_a = session_ff;
                     result.frame_length = LEN_SESSION;
                  end
               end
               PH_END: begin
                  result.frame_kind   = KIND_END;
                  result.frame_word_a = session_ff;
                  result.frame_length = LEN_SESSION;
               end
               PH_VERIFY: begin
                  result.frame_kind   = KIND_VERIFY;
                  result.frame_word_a = session_ff;
                  result.frame_length = LEN_SESSION;
               end
               PH_ACTIVATE: begin
                  result.frame_kind   = KIND_ACTIVATE;
                  result.frame_word_a = session_ff;
                  result.frame_length = LEN_SESSION;
               end
               PH_REBOOT: begin
                  result.frame_kind   = KIND_REBOOT;
                  result.frame_length = LEN_REBOOT;
               end
               default: begin
                  result.status = ST_STATE;
               end
            endcase
         end
         OP_ACCEPT: begin
            if (item.reply_kind == REPLY_NACK || item.reply_kind == REPLY_ERROR) begin
               ok = 1'b0;
            end else begin
               case (phase_ff)
                  PH_ENTER: begin
                     if (item.sent_kind == KIND_ENTER) begin
                        phase_in = PH_BEGIN;
                        ok       = 1'b1;
                     end
                  end
                  PH_BEGIN: begin
                     // session and offset are kept even when the check fails
                     if (item.sent_kind == KIND_BEGIN && item.reply_length == LEN_REPLY_PAIR) begin
                        session_in = item.reply_word_a;
                        offset_in  = item.reply_word_b;
                        if (item.reply_word_a != '0 &&
                            item.reply_word_b <= csr.image_length) begin
                           phase_in = phase_after_b;
                           ok       = 1'b1;
                        end
                     end
                  end
                  PH_TRANSFER: begin
                     if (item.sent_kind == KIND_DATA && item.reply_length == LEN_REPLY_WORD) begin
                        offset_in = item.reply_word_a;
                        if (item.reply_word_a == chunk_end_ff &&
                            item.reply_word_a <= csr.image_length) begin
                           phase_in = phase_after_a;
                           ok       = 1'b1;
                        end
                     end
                  end
                  PH_RECOVER: begin
                     if (item.sent_kind == KIND_STATUS && item.reply_length == LEN_REPLY_PAIR &&
                         item.reply_word_a == session_ff) begin
                        offset_in = item.reply_word_b;
                        if (item.reply_word_b <= csr.image_length) begin
                           phase_in = phase_after_b;
                           ok       = 1'b1;
                        end
                     end
                  end
                  PH_END: begin
                     if (item.sent_kind == KIND_END) begin
                        phase_in = PH_VERIFY;
                        ok       = 1'b1;
                     end
                  end
                  PH_VERIFY: begin
                     if (item.sent_kind == KIND_VERIFY && item.reply_length == LEN_REPLY_WORD &&
                         item.reply_word_a == csr.image_checksum) begin
                        phase_in = PH_ACTIVATE;
                        ok       = 1'b1;
                     end
                  end
                  PH_ACTIVATE: begin
                     if (item.sent_kind == KIND_ACTIVATE) begin
                        phase_in = PH_REBOOT;
                        ok       = 1'b1;
                     end
                  end
                  PH_REBOOT: begin
                     if (item.sent_kind == KIND_REBOOT) begin
                        phase_in = PH_COMPLETE;
                        ok       = 1'b1;
                     end
                  end
                  default: ok = 1'b0;
               endcase
            end
            if (!ok) begin
               phase_in      = PH_ERROR;
               result.status = ST_PROTOCOL;
            end
         end
         default: begin
            if (session_ff == '0 || (phase_ff != PH_TRANSFER && phase_ff != PH_RECOVER)) begin
               result.status = ST_STATE;
            end else if (retry_count_ff >= RETRY_CAP) begin
               phase_in      = PH_ERROR;
               result.status = ST_TIMEOUT;
            end else begin
               retry_count_in = retry_count_ff + 2'd1;
               phase_in       = PH_RECOVER;
            end
         end
      endcase

      result.phase      = phase_in;
      result.busy_res   = (phase_in != PH_IDLE) && (phase_in != PH_COMPLETE) &&
                          (phase_in != PH_ERROR);
      result.chunks_out = chunk_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         session_ff     <= '0;
         offset_ff      <= '0;
         chunk_end_ff   <= '0;
         chunk_count_ff <= '0;
         retry_count_ff <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         session_ff     <= session_in;
         offset_ff      <= offset_in;
         chunk_end_ff   <= chunk_end_in;
         chunk_count_ff <= chunk_count_in;
         retry_count_ff <= retry_count_in;
      end
   end

   a_timeout_only_at_cap : assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_TIMEOUT |-> retry_count_ff >= RETRY_CAP)
      else $error("timeout reported before the retry cap was reached");

   a_data_counts : assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_OK && item.opcode == OP_BUILD &&
      result.frame_kind == KIND_DATA |=> chunk_count_ff == $past(chunk_count_ff) + 32'd1)
      else $error("data request built without advancing the chunk count");

   a_session_live : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TRANSFER || phase_ff == PH_RECOVER || phase_ff == PH_END ||
      phase_ff == PH_VERIFY || phase_ff == PH_ACTIVATE || phase_ff == PH_REBOOT
      |-> session_ff != '0)
      else $error("session phase reached with a zero session id");

   a_failed_frame_empty : assert property (@(posedge clock) disable iff (reset)
      step && result.status != ST_OK |-> result.frame_length == '0 &&
      result.frame_kind == KIND_ENTER && result.data_length == '0)
      else $error("frame fields set on a failed transaction");

endmodule

[hdl/firmware_upgrade_host_sequencer.sv]
// Requests pass the input register, then the result register; response back-pressure
//   stalls both. Throughput: one transaction per cycle while the response channel is
//   ready; each item is decided by one pass through the state logic between the two
//   registers, so the next item sees the updated session state. Reset (synchronous,
//   active high): phase idle, session, offset, chunk end, chunk and retry counts and
//   all configuration registers cleared; both pipeline registers emptied.
module firmware_upgrade_host_sequencer
   import fuhs_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int VERSION_MAX = VERSION_MAX_DEF,
   parameter int RETRY_LIMIT = RETRY_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   fuhs_req_if.sink             req_chan,
   fuhs_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data
);

   csr_type      csr;
   req_item_type req_item_in;
   req_item_type req_item_ff;
   logic         req_valid_ff;
   rsp_item_type rsp_item_in;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff;
   logic         advance;
   logic         req_ready;

   fuhs_csr #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .VERSION_MAX (VERSION_MAX)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   fuhs_engine #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .RETRY_LIMIT (RETRY_LIMIT)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_item_ff),
      .csr    (csr),
      .result (rsp_item_in)
   );

   // advance when the result register is free or being drained this cycle
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = !req_valid_ff || advance;

   always_comb begin
      req_item_in.opcode       = req_chan.opcode;
      req_item_in.sent_kind    = req_chan.sent_kind;
      req_item_in.reply_kind   = req_chan.reply_kind;
      req_item_in.reply_length = req_chan.reply_length;
      req_item_in.reply_word_a = req_chan.reply_word_a;
      req_item_in.reply_word_b = req_chan.reply_word_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_chan.valid;
      end
      if (req_ready && req_chan.valid) begin
         req_item_ff <= req_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_valid_ff <= advance;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_item_ff.status;
   assign rsp_chan.frame_kind   = rsp_item_ff.frame_kind;
   assign rsp_chan.frame_word_a = rsp_item_ff.frame_word_a;
   assign rsp_chan.frame_word_b = rsp_item_ff.frame_word_b;
   assign rsp_chan.frame_half   = rsp_item_ff.frame_half;
   assign rsp_chan.frame_length = rsp_item_ff.frame_length;
   assign rsp_chan.data_length  = rsp_item_ff.data_length;
   assign rsp_chan.phase        = rsp_item_ff.phase;
   assign rsp_chan.busy_res     = rsp_item_ff.busy_res;
   assign rsp_chan.chunks_out   = rsp_item_ff.chunks_out;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the firmware upgrade host sequencer: random sessions, live checks.
`timescale 1ns / 1ps

module tb_top;
   import fuhs_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 430;
   localparam int SETTLE_CYCLES = 4;
   localparam int CHUNK_CAP    = MAX_PAYLOAD_DEF - DATA_HDR_BYTES;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_LENGTH;
   logic [WORD_W-1:0]    csr_write_data = '0;

   fuhs_req_if req_chan ();
   fuhs_rsp_if rsp_chan ();

   firmware_upgrade_host_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // register shadows
   logic [31:0] cfg_image_len = '0;
   logic [31:0] cfg_image_crc = '0;
   logic [15:0] cfg_chunk_limit = '0;
   logic [5:0]  cfg_label_len = '0;

   // session state as the sequencer should hold it
   phase_type   host_phase = PH_IDLE;
   logic [31:0] host_session = '0;
   logic [31:0] host_offset = '0;
   logic [31:0] host_chunk_end = '0;
   logic [31:0] host_chunks = '0;
   logic [1:0]  host_retries = '0;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   req_item_type item_on_bus;

   int queued_count = 0;
   int fault_count = 0;
   int cycle_count = 0;

   // stimulus plan for the session being generated
   logic [31:0] plan_session = '0;
   logic [31:0] plan_offset = '0;
   bit          plan_open = 1'b0;

   function automatic phase_type phase_after_offset();
      return (host_offset == cfg_image_len) ? PH_END : PH_TRANSFER;
   endfunction

   function automatic rsp_item_type sequence_step(input req_item_type item);
      rsp_item_type r;
      status_type   st;
      logic         ok;
      logic [31:0]  remaining;
      logic [31:0]  chunk;
      r = '0;
      st = ST_OK;
      ok = 1'b0;
      case (item.opcode)
         OP_START: begin
            if (cfg_image_len == '0 || cfg_chunk_limit == '0 ||
                {16'd0, cfg_chunk_limit} > CHUNK_CAP ||
                cfg_label_len == '0 || {26'd0, cfg_label_len} > VERSION_MAX_DEF) begin
               st = ST_INVALID;
            end else begin
               host_session = '0;
               host_offset = '0;
               host_chunk_end = '0;
               host_chunks = '0;
               host_retries = '0;
               host_phase = PH_ENTER;
            end
         end
         OP_BUILD: begin
            case (host_phase)
               PH_ENTER: r.frame_kind = KIND_ENTER;
               PH_BEGIN: begin
                  r.frame_kind = KIND_BEGIN;
                  r.frame_word_a = cfg_image_len;
                  r.frame_word_b = cfg_image_crc;
                  r.frame_half = cfg_chunk_limit;
                  r.frame_length = LEN_BEGIN_HDR + {3'b000, cfg_label_len};
               end
               PH_TRANSFER: begin
                  if (host_offset >= cfg_image_len) begin
                     st = ST_STATE;
                  end else begin
                     remaining = cfg_image_len - host_offset;
                     chunk = (remaining < {16'd0, cfg_chunk_limit}) ? remaining
                                                                    : {16'd0, cfg_chunk_limit};
                     if (chunk > CHUNK_CAP) chunk = CHUNK_CAP;
                     r.frame_kind = KIND_DATA;
                     r.frame_word_a = host_session;
                     r.frame_word_b = host_offset;
                     r.frame_length = 9'(DATA_HDR_BYTES + chunk);
                     r.data_length = chunk[7:0];
                     host_chunk_end = host_offset + chunk;
                     host_chunks = host_chunks + 32'd1;
                  end
               end
               PH_RECOVER: begin
                  if (host_session == '0) begin
                     st = ST_STATE;
                  end else begin
                     r.frame_kind = KIND_STATUS;
                     r.frame_word_a = host_session;
                     r.frame_length = LEN_SESSION;
                  end
               end
               PH_END, PH_VERIFY, PH_ACTIVATE: begin
                  r.frame_kind = (host_phase == PH_END) ? KIND_END :
                                 (host_phase == PH_VERIFY) ? KIND_VERIFY : KIND_ACTIVATE;
                  r.frame_word_a = host_session;
                  r.frame_length = LEN_SESSION;
               end
               PH_REBOOT: begin
                  r.frame_kind = KIND_REBOOT;
                  r.frame_length = LEN_REBOOT;
               end
               default: st = ST_STATE;
            endcase
         end
         OP_ACCEPT: begin
            if (item.reply_kind != REPLY_NACK && item.reply_kind != REPLY_ERROR) begin
               case (host_phase)
                  PH_ENTER: begin
                     if (item.sent_kind == KIND_ENTER) begin
                        host_phase = PH_BEGIN;
                        ok = 1'b1;
                     end
                  end
                  PH_BEGIN: begin
                     // session and offset are kept even when the checks fail
                     if (item.sent_kind == KIND_BEGIN && item.reply_length == LEN_REPLY_PAIR) begin
                        host_session = item.reply_word_a;
                        host_offset = item.reply_word_b;
                        if (host_session != '0 && host_offset <= cfg_image_len) begin
                           host_phase = phase_after_offset();
                           ok = 1'b1;
                        end
                     end
                  end
                  PH_TRANSFER: begin
                     if (item.sent_kind == KIND_DATA && item.reply_length == LEN_REPLY_WORD) begin
                        host_offset = item.reply_word_a;
                        if (host_offset == host_chunk_end && host_offset <= cfg_image_len) begin
                           host_phase = phase_after_offset();
                           ok = 1'b1;
                        end
                     end
                  end
                  PH_RECOVER: begin
                     if (item.sent_kind == KIND_STATUS && item.reply_length == LEN_REPLY_PAIR &&
                         item.reply_word_a == host_session) begin
                        host_offset = item.reply_word_b;
                        if (host_offset <= cfg_image_len) begin
                           host_phase = phase_after_offset();
                           ok = 1'b1;
                        end
                     end
                  end
                  PH_END: begin
                     if (item.sent_kind == KIND_END) begin
                        host_phase = PH_VERIFY;
                        ok = 1'b1;
                     end
                  end
                  PH_VERIFY: begin
                     if (item.sent_kind == KIND_VERIFY && item.reply_length == LEN_REPLY_WORD &&
                         item.reply_word_a == cfg_image_crc) begin
                        host_phase = PH_ACTIVATE;
                        ok = 1'b1;
                     end
                  end
                  PH_ACTIVATE: begin
                     if (item.sent_kind == KIND_ACTIVATE) begin
                        host_phase = PH_REBOOT;
                        ok = 1'b1;
                     end
                  end
                  PH_REBOOT: begin
                     if (item.sent_kind == KIND_REBOOT) begin
                        host_phase = PH_COMPLETE;
                        ok = 1'b1;
                     end
                  end
                  default: ok = 1'b0;
               endcase
            end
            if (!ok) begin
               host_phase = PH_ERROR;
               st = ST_PROTOCOL;
            end
         end
         default: begin
            if (host_session == '0 || (host_phase != PH_TRANSFER && host_phase != PH_RECOVER)) begin
               st = ST_STATE;
            end else if ({30'd0, host_retries} >= RETRY_LIMIT_DEF) begin
               host_phase = PH_ERROR;
               st = ST_TIMEOUT;
            end else begin
               host_retries = host_retries + 2'd1;
               host_phase = PH_RECOVER;
            end
         end
      endcase
      if (st != ST_OK) r = '0;
      r.status = st;
      r.phase = host_phase;
      r.busy_res = (host_phase != PH_IDLE && host_phase != PH_COMPLETE && host_phase != PH_ERROR);
      r.chunks_out = host_chunks;
      return r;
   endfunction

   // ---------------------------------------------------------------- request driver
   int  burst_left = 0;
   int  gap_left = 0;
   bit  drain_wait = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
         drain_wait = 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_rsps.push_back(sequence_step(item_on_bus));
         if (!req_chan.valid || req_chan.ready) begin
            if (drain_wait && expected_rsps.size() == 0) drain_wait = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (drain_wait || pending_reqs.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else begin
               item_on_bus = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.opcode <= item_on_bus.opcode;
               req_chan.sent_kind <= item_on_bus.sent_kind;
               req_chan.reply_kind <= item_on_bus.reply_kind;
               req_chan.reply_length <= item_on_bus.reply_length;
               req_chan.reply_word_a <= item_on_bus.reply_word_a;
               req_chan.reply_word_b <= item_on_bus.reply_word_b;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                  // now and then hold off until every outstanding response is back
                  drain_wait = ($urandom_range(0, 11) == 0);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- response monitor
   int stall_cycle = 0;
   int stall_mode = 0;

   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_cycle = 0;
         stall_mode = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status = rsp_chan.status;
            got.frame_kind = rsp_chan.frame_kind;
            got.frame_word_a = rsp_chan.frame_word_a;
            got.frame_word_b = rsp_chan.frame_word_b;
            got.frame_half = rsp_chan.frame_half;
            got.frame_length = rsp_chan.frame_length;
            got.data_length = rsp_chan.data_length;
            got.phase = rsp_chan.phase;
            got.busy_res = rsp_chan.busy_res;
            got.chunks_out = rsp_chan.chunks_out;
            if (expected_rsps.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: response with nothing outstanding: st=%0d ph=%0d",
                           $realtime, got.status, got.phase);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status || got.frame_kind !== want.frame_kind ||
                   got.frame_word_a !== want.frame_word_a ||
                   got.frame_word_b !== want.frame_word_b ||
                   got.frame_half !== want.frame_half || got.frame_length !== want.frame_length ||
                   got.data_length !== want.data_length || got.phase !== want.phase ||
                   got.busy_res !== want.busy_res || got.chunks_out !== want.chunks_out) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("%0t: mismatch", $realtime);
                     $display("  exp st=%0d k=%0d a=%h b=%h h=%h len=%0d dl=%0d ph=%0d bsy=%0d n=%0d",
                              want.status, want.frame_kind, want.frame_word_a, want.frame_word_b,
                              want.frame_half, want.frame_length, want.data_length, want.phase,
                              want.busy_res, want.chunks_out);
                     $display("  got st=%0d k=%0d a=%h b=%h h=%h len=%0d dl=%0d ph=%0d bsy=%0d n=%0d",
                              got.status, got.frame_kind, got.frame_word_a, got.frame_word_b,
                              got.frame_half, got.frame_length, got.data_length, got.phase,
                              got.busy_res, got.chunks_out);
                  end
               end
            end
         end
         stall_cycle++;
         if (stall_cycle % 96 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom_range(0, 1));
            2: rsp_chan.ready <= (stall_cycle % 6 == 0);
            default: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[firmware_upgrade_host_sequencer] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_IMAGE_LENGTH:   cfg_image_len = data;
         CSR_IMAGE_CHECKSUM: cfg_image_crc = data;
         CSR_CHUNK_LIMIT:    cfg_chunk_limit = data[15:0];
         default:            cfg_label_len = data[5:0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_chan.valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_item(input opcode_type op, input logic [2:0] sent, input logic [3:0] kind,
                             input logic [8:0] len, input logic [31:0] wa, input logic [31:0] wb);
      req_item_type it;
      it.opcode = op;
      it.sent_kind = sent;
      it.reply_kind = kind;
      it.reply_length = len;
      it.reply_word_a = wa;
      it.reply_word_b = wb;
      pending_reqs.push_back(it);
      queued_count++;
   endtask

   // payload fields are don't-care for everything but a response
   task automatic queue_plain(input opcode_type op);
      queue_item(op, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                 9'($urandom_range(0, 511)), $urandom, $urandom);
   endtask

   task automatic queue_reply(input kind_type sent, input logic [8:0] len, input logic [31:0] wa,
                              input logic [31:0] wb, input bit clean);
      logic [3:0]  kind;
      logic [2:0]  s;
      logic [8:0]  l;
      logic [31:0] a;
      logic [31:0] b;
      kind = 4'($urandom_range(0, 13));
      if (kind >= REPLY_NACK) kind = kind + 4'd2;
      s = sent;
      l = len;
      a = wa;
      b = wb;
      if (!clean && $urandom_range(0, 24) == 0) begin
         case ($urandom_range(0, 4))
            0: kind = ($urandom_range(0, 1) != 0) ? REPLY_NACK : REPLY_ERROR;
            1: s = 3'($urandom_range(0, 7));
            2: l = 9'($urandom_range(0, 511));
            3: a = a ^ (32'd1 << $urandom_range(0, 31));
            default: b = $urandom;
         endcase
      end
      queue_item(OP_ACCEPT, s, kind, l, a, b);
   endtask

   task automatic queue_noise(input int count);
      repeat (count)
         queue_item(opcode_type'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)), $urandom, $urandom);
   endtask

   // one upgrade session as a well-behaved device would answer it, with rare faults
   task automatic queue_session(input bit resume, input int max_chunks, input bit clean);
      int          done;
      logic [31:0] eff;
      logic [31:0] step;
      eff = ({16'd0, cfg_chunk_limit} > CHUNK_CAP) ? CHUNK_CAP : {16'd0, cfg_chunk_limit};
      if (!resume) begin
         queue_plain(OP_START);
         queue_plain(OP_BUILD);
         queue_reply(KIND_ENTER, 9'($urandom_range(0, 511)), $urandom, $urandom, clean);
         queue_plain(OP_BUILD);
         plan_session = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
         if (plan_session == '0) plan_session = 32'd1;
         case ($urandom_range(0, 9))
            0: plan_offset = cfg_image_len;
            1: begin
               step = $urandom_range(0, 600);
               plan_offset = (step > cfg_image_len) ? 32'd0 : cfg_image_len - step;
            end
            default: plan_offset = '0;
         endcase
         queue_reply(KIND_BEGIN, LEN_REPLY_PAIR, plan_session, plan_offset, clean);
      end else begin
         queue_plain(OP_BUILD);
      end
      done = 0;
      while (plan_offset < cfg_image_len && done < max_chunks) begin
         queue_plain(OP_BUILD);
         step = (cfg_image_len - plan_offset < eff) ? cfg_image_len - plan_offset : eff;
         if (!clean && $urandom_range(0, 11) == 0) begin
            // timeout: a run of recovery attempts, then a status exchange
            repeat ($urandom_range(1, 4)) queue_plain(OP_RECOVER);
            queue_plain(OP_BUILD);
            queue_reply(KIND_STATUS, LEN_REPLY_PAIR, plan_session, plan_offset, clean);
         end else begin
            plan_offset = plan_offset + step;
            queue_reply(KIND_DATA, LEN_REPLY_WORD, plan_offset, $urandom, clean);
         end
         done++;
      end
      plan_open = (plan_offset < cfg_image_len);
      if (!plan_open) begin
         queue_plain(OP_BUILD);
         queue_reply(KIND_END, 9'($urandom_range(0, 511)), $urandom, $urandom, clean);
         queue_plain(OP_BUILD);
         queue_reply(KIND_VERIFY, LEN_REPLY_WORD, cfg_image_crc, $urandom, clean);
         queue_plain(OP_BUILD);
         queue_reply(KIND_ACTIVATE, 9'($urandom_range(0, 511)), $urandom, $urandom, clean);
         queue_plain(OP_BUILD);
         queue_reply(KIND_REBOOT, 9'($urandom_range(0, 511)), $urandom, $urandom, clean);
      end
   endtask

   task automatic program_random_config();
      logic [15:0] lim;
      logic [15:0] lim_pad;
      logic [31:0] len;
      logic [31:0] crc;
      logic [31:0] eff;
      logic [5:0]  lab;
      logic [25:0] lab_pad;
      case ($urandom_range(0, 19))
         0: lim = 16'd0;
         1: lim = 16'd1;
         2: lim = 16'(CHUNK_CAP);
         3: lim = 16'(CHUNK_CAP + 1);
         4: lim = 16'hFFFF;
         5: lim = 16'($urandom_range(0, 65535));
         default: lim = 16'($urandom_range(1, CHUNK_CAP));
      endcase
      eff = (lim == '0) ? 32'd1 : ({16'd0, lim} > CHUNK_CAP) ? CHUNK_CAP : {16'd0, lim};
      case ($urandom_range(0, 19))
         0: len = '0;
         1: len = 32'hFFFF_FFFF;
         2: len = $urandom;
         default: len = eff * $urandom_range(0, 5) + $urandom_range(1, eff);
      endcase
      case ($urandom_range(0, 9))
         0: crc = '0;
         1: crc = 32'hFFFF_FFFF;
         default: crc = $urandom;
      endcase
      case ($urandom_range(0, 19))
         0: lab = 6'd0;
         1: lab = 6'(VERSION_MAX_DEF);
         2: lab = 6'(VERSION_MAX_DEF + 1);
         3: lab = 6'd63;
         4: lab = 6'd1;
         default: lab = 6'($urandom_range(1, VERSION_MAX_DEF));
      endcase
      lim_pad = 16'($urandom);
      lab_pad = 26'($urandom);
      write_reg(CSR_IMAGE_LENGTH, len);
      write_reg(CSR_IMAGE_CHECKSUM, crc);
      write_reg(CSR_CHUNK_LIMIT, {lim_pad, lim});
      write_reg(CSR_LABEL_LENGTH, {lab_pad, lab});
      @(negedge clock);
   endtask

   initial begin : main_seq
      logic [15:0] lim;
      logic [15:0] lim_pad;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_START;
      req_chan.sent_kind = KIND_ENTER;
      req_chan.reply_kind = '0;
      req_chan.reply_length = '0;
      req_chan.reply_word_a = '0;
      req_chan.reply_word_b = '0;
      rsp_chan.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers still cleared: every operation is refused
      queue_plain(OP_START);
      queue_plain(OP_BUILD);
      queue_reply(KIND_ENTER, LEN_REPLY_PAIR, '0, '0, 1'b1);
      queue_plain(OP_RECOVER);
      wait_drained();

      // smallest image, widest chunk and label, all-ones checksum
      write_reg(CSR_IMAGE_LENGTH, 32'd1);
      write_reg(CSR_IMAGE_CHECKSUM, 32'hFFFF_FFFF);
      write_reg(CSR_CHUNK_LIMIT, CHUNK_CAP);
      write_reg(CSR_LABEL_LENGTH, VERSION_MAX_DEF);
      @(negedge clock);
      queue_session(1'b0, 2, 1'b1);
      queue_plain(OP_BUILD);
      queue_plain(OP_RECOVER);
      queue_item(OP_ACCEPT, KIND_REBOOT, REPLY_NACK, '0, '0, '0);

      while (queued_count < RANDOM_ITEMS) begin
         wait_drained();
         if (plan_open && $urandom_range(0, 2) == 0) begin
            // change the chunk size mid-transfer, sometimes pull the image end back
            case ($urandom_range(0, 4))
               0: lim = 16'hFFFF;
               1: lim = 16'd0;
               2: lim = 16'(CHUNK_CAP + 1);
               default: lim = 16'($urandom_range(1, CHUNK_CAP));
            endcase
            lim_pad = 16'($urandom);
            write_reg(CSR_CHUNK_LIMIT, {lim_pad, lim});
            if ($urandom_range(0, 3) == 0) write_reg(CSR_IMAGE_LENGTH, plan_offset);
            @(negedge clock);
            queue_session(1'b1, $urandom_range(1, 8), 1'b0);
         end else begin
            program_random_config();
            repeat ($urandom_range(1, 2)) begin
               queue_session(1'b0, $urandom_range(1, 10), 1'b0);
               queue_noise($urandom_range(0, 3));
            end
         end
      end
      wait_drained();

      if (expected_rsps.size() != 0) fault_count++;
      if (fault_count == 0)
         $display("[firmware_upgrade_host_sequencer] OK");
      else
         $display("[firmware_upgrade_host_sequencer] ERROR");
      $finish;
   end

endmodule
